// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the range encoder checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset
`define RBO_ASSERT_CLK(label, clock, reset_n, prop) \
    label: assert property (@(posedge clock) disable iff (!reset_n) prop) \
        else $error("range encoder port check failed");

// Assertion on the local clk and rst_n
`define RBO_ASSERT(label, prop) `RBO_ASSERT_CLK(label, clk, rst_n, prop)

`endif

// ===== rtl/rbo_pkg.sv =====
// ----------------------------------------------------------------------------
// rbo_pkg
// Types and constants shared by the range encoder byte output block.
// ----------------------------------------------------------------------------
package rbo_pkg;

    localparam int WORD_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int CUM_W     = 16;
    localparam int FREQ_W    = 8;
    localparam int TOTAL_W   = 16;
    localparam int TOP_SHIFT = 24;
    localparam int CNT_W     = $clog2(WORD_W);
    localparam int MUL_W     = CUM_W + WORD_W;

    localparam logic [WORD_W-1:0] LOW_INIT  = '0;
    localparam logic [WORD_W-1:0] HIGH_INIT = 32'hFFFF_FFFF;
    localparam logic [BYTE_W-1:0] BYTE_FILL = 8'hFF;

    // Operation codes
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    // One input request
    typedef struct packed {
        logic               operation;
        logic [CUM_W-1:0]   cum_start;
        logic [FREQ_W-1:0]  freq;
        logic [TOTAL_W-1:0] total;
    } sym_item_t;

    // One output request
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
    } byte_item_t;

    // Divider status towards the sequencer
    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_stat_t;

endpackage

// ===== rtl/rbo_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for symbol requests and output byte requests.
// ----------------------------------------------------------------------------
interface rbo_sym_if;
    logic               valid;
    logic               ready;
    rbo_pkg::sym_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbo_byte_if;
    logic                valid;
    logic                ready;
    rbo_pkg::byte_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/rbo_div.sv =====
// ----------------------------------------------------------------------------
// rbo_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle. A zero divisor yields an all-ones quotient.
// ----------------------------------------------------------------------------
module rbo_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rbo_pkg::WORD_W-1:0]    num,
    input  logic [rbo_pkg::TOTAL_W-1:0]   den,
    output logic [rbo_pkg::WORD_W-1:0]    quot,
    output rbo_pkg::div_stat_t            stat
);

    logic [rbo_pkg::WORD_W-1:0]  quot_reg, quot_next;
    logic [rbo_pkg::TOTAL_W-1:0] rem_reg, rem_next;
    logic [rbo_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [rbo_pkg::TOTAL_W:0]   trial;
    logic [rbo_pkg::TOTAL_W:0]   den_ext;
    logic                        fits;

    // one restoring step
    assign trial   = {rem_reg, quot_reg[rbo_pkg::WORD_W-1]};
    assign den_ext = {1'b0, den};
    assign fits    = (trial >= den_ext);

    always_comb
    begin
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rbo_pkg::TOTAL_W'(trial - den_ext);
            end
            else
            begin
                rem_next = trial[rbo_pkg::TOTAL_W-1:0];
            end
            quot_next = {quot_reg[rbo_pkg::WORD_W-2:0], fits};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == rbo_pkg::CNT_W'(rbo_pkg::WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quot           = quot_reg;
    assign stat.done      = done_reg;
    assign stat.quot_zero = (quot_reg == '0);

endmodule

// ===== rtl/range_encoder_byte_output_core.sv =====
// ----------------------------------------------------------------------------
// range_encoder_byte_output_core
// Carry-less 32-bit range encoder emitting the compressed bytes of each request.
// ----------------------------------------------------------------------------
// Takes one symbol or flush request at a time; sym_chan.ready is high only
// between requests. An encode request runs the bit-serial restoring divider
// that forms mult, then a shared 16x32 multiplier used twice for the new low
// and high bounds, then the byte shift loop. When mult comes out zero, the
// four bytes of low are shifted out and the division runs again. Bytes leave
// through an output register with one byte held back, so the final byte of
// each request can carry last_of_run; a byte waiting on byte_chan stalls the
// shift loop.
// ----------------------------------------------------------------------------
module range_encoder_byte_output_core (
    input  logic      clk,
    input  logic      rst_n,
    rbo_sym_if.sink   sym_chan,
    rbo_byte_if.source byte_chan
);

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_DIV_GO   = 4'd1;
    localparam logic [3:0] ST_DIV_WAIT = 4'd2;
    localparam logic [3:0] ST_CHECK    = 4'd3;
    localparam logic [3:0] ST_MUL_LOW  = 4'd4;
    localparam logic [3:0] ST_ADD_LOW  = 4'd5;
    localparam logic [3:0] ST_MUL_HIGH = 4'd6;
    localparam logic [3:0] ST_ADD_HIGH = 4'd7;
    localparam logic [3:0] ST_SHIFT    = 4'd8;
    localparam logic [3:0] ST_FINISH   = 4'd9;

    logic [3:0]                 state_reg, state_next;
    logic [rbo_pkg::WORD_W-1:0] low_reg, low_next;
    logic [rbo_pkg::WORD_W-1:0] high_reg, high_next;
    logic                       redo_reg, redo_next;
    rbo_pkg::sym_item_t         item_reg, item_next;
    logic [rbo_pkg::WORD_W-1:0] prod_reg, prod_next;
    logic [rbo_pkg::BYTE_W-1:0] pend_reg, pend_next;
    logic                       pend_valid_reg, pend_valid_next;
    rbo_pkg::byte_item_t        out_reg, out_next;
    logic                       out_valid_reg, out_valid_next;

    logic                       sym_fire;
    logic                       out_free;
    logic                       tops_agree;
    logic                       div_start;
    logic [rbo_pkg::WORD_W-1:0] span;
    logic [rbo_pkg::WORD_W-1:0] mult;
    rbo_pkg::div_stat_t         div_stat;
    logic [rbo_pkg::CUM_W-1:0]  mul_a;
    logic [rbo_pkg::MUL_W-1:0]  mul_full;
    logic [rbo_pkg::BYTE_W-1:0] top_high;
    logic [rbo_pkg::BYTE_W-1:0] top_low;

    assign sym_chan.ready = (state_reg == ST_IDLE);
    assign sym_fire       = sym_chan.valid && sym_chan.ready;
    assign out_free       = !out_valid_reg || byte_chan.ready;

    assign top_high   = high_reg[rbo_pkg::WORD_W-1:rbo_pkg::TOP_SHIFT];
    assign top_low    = low_reg[rbo_pkg::WORD_W-1:rbo_pkg::TOP_SHIFT];
    assign tops_agree = (top_high == top_low);

    // shared divider
    assign span      = high_reg - low_reg;
    assign div_start = (state_reg == ST_DIV_GO);

    rbo_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (span),
        .den   (item_reg.total),
        .quot  (mult),
        .stat  (div_stat)
    );

    // shared multiplier: cum_start first, then freq
    assign mul_a    = (state_reg == ST_MUL_LOW) ? item_reg.cum_start
                                                : rbo_pkg::CUM_W'(item_reg.freq);
    assign mul_full = mul_a * mult;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        redo_next       = redo_reg;
        item_next       = item_reg;
        prod_next       = prod_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;

        // output register drains on its own handshake
        if (out_valid_reg && byte_chan.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (sym_fire)
                begin
                    item_next = sym_chan.data;
                    redo_next = 1'b0;
                    if (sym_chan.data.operation == rbo_pkg::OP_FLUSH)
                    begin
                        // collapse the interval to low
                        high_next  = low_reg;
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_DIV_GO:
            begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (div_stat.quot_zero)
                begin
                    // range too narrow: flush low, then divide again
                    high_next  = low_reg;
                    redo_next  = 1'b1;
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_MUL_LOW;
                end
            end
            ST_MUL_LOW:
            begin
                prod_next  = mul_full[rbo_pkg::WORD_W-1:0];
                state_next = ST_ADD_LOW;
            end
            ST_ADD_LOW:
            begin
                low_next   = low_reg + prod_reg;
                state_next = ST_MUL_HIGH;
            end
            ST_MUL_HIGH:
            begin
                prod_next  = mul_full[rbo_pkg::WORD_W-1:0];
                state_next = ST_ADD_HIGH;
            end
            ST_ADD_HIGH:
            begin
                high_next  = low_reg + prod_reg - rbo_pkg::WORD_W'(1);
                state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (tops_agree)
                begin
                    // hold one byte back so the final one can be marked
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next.out_byte    = pend_reg;
                            out_next.last_of_run = 1'b0;
                            out_valid_next       = 1'b1;
                        end
                        pend_next       = top_high;
                        pend_valid_next = 1'b1;
                        low_next        = {low_reg[rbo_pkg::TOP_SHIFT-1:0],
                                           rbo_pkg::BYTE_W'(0)};
                        high_next       = {high_reg[rbo_pkg::TOP_SHIFT-1:0],
                                           rbo_pkg::BYTE_FILL};
                    end
                end
                else if (redo_reg)
                begin
                    redo_next  = 1'b0;
                    state_next = ST_DIV_GO;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next.out_byte    = pend_reg;
                    out_next.last_of_run = 1'b1;
                    out_valid_next       = 1'b1;
                    pend_valid_next      = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            low_reg        <= rbo_pkg::LOW_INIT;
            high_reg       <= rbo_pkg::HIGH_INIT;
            redo_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            redo_reg       <= redo_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        prod_reg <= prod_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign byte_chan.valid = out_valid_reg;
    assign byte_chan.data  = out_reg;

endmodule

// ===== rtl/rbo_checker.sv =====
// ----------------------------------------------------------------------------
// rbo_checker
// Port-level checks on the range encoder core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbo_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       sym_valid,
    input logic                       sym_ready,
    input logic                       sym_op,
    input logic                       byte_valid,
    input logic                       byte_ready,
    input logic [rbo_pkg::BYTE_W-1:0] byte_value,
    input logic                       byte_last
);

    logic flush_req;
    logic byte_stall;

    assign flush_req  = sym_valid && sym_ready && (sym_op == rbo_pkg::OP_FLUSH);
    assign byte_stall = byte_valid && !byte_ready;

    // one request at a time
    `RBO_ASSERT(a_busy_after_accept, sym_valid && sym_ready |=> !sym_ready)

    // a flush shifts four bytes before the core is free again
    `RBO_ASSERT(a_flush_busy, flush_req |=> !sym_ready [*4])

    // between requests only a run-closing byte can still be waiting
    `RBO_ASSERT(a_idle_last, sym_ready && byte_valid |-> byte_last)

    // a stalled byte holds
    `RBO_ASSERT(a_byte_hold, byte_stall |=> byte_valid && $stable({byte_value, byte_last}))

endmodule

bind range_encoder_byte_output_core rbo_checker u_rbo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .sym_valid  (sym_chan.valid),
    .sym_ready  (sym_chan.ready),
    .sym_op     (sym_chan.data.operation),
    .byte_valid (byte_chan.valid),
    .byte_ready (byte_chan.ready),
    .byte_value (byte_chan.data.out_byte),
    .byte_last  (byte_chan.data.last_of_run)
);

// ===== verif/range_coder_byte_checker.sv =====
// ----------------------------------------------------------------------------
// range_coder_byte_checker
// Watches the symbol and byte channels, keeps its own copy of the coding
// interval, works out the bytes each accepted request must give and compares
// every accepted byte with the oldest one still owed.
// ----------------------------------------------------------------------------
module range_coder_byte_checker (
    input  logic        clk,
    input  logic        rst_n,
    rbo_sym_if          sym_mon,
    rbo_byte_if         byte_mon,
    output int unsigned mismatches,
    output int unsigned outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_BYTES_PER_REQUEST = 8;
    localparam int WORD_W                = rbo_pkg::WORD_W;
    localparam int BYTE_W                = rbo_pkg::BYTE_W;

    logic [WORD_W-1:0]    bound_low;
    logic [WORD_W-1:0]    bound_high;
    rbo_pkg::byte_item_t  owed_bytes[$];

    // Quotient of the interval span by the context total; a zero total
    // gives all ones, as the restoring divider does
    function automatic logic [WORD_W-1:0] span_quotient(
        logic [WORD_W-1:0]           span,
        logic [rbo_pkg::TOTAL_W-1:0] total
    );
        if (total == '0)
            return '1;
        return span / WORD_W'(total);
    endfunction

    // Emit every top byte on which the bounds agree
    task automatic shift_agreeing_bytes(inout int emitted);
        rbo_pkg::byte_item_t b;
        while (bound_high[WORD_W-1 -: BYTE_W] == bound_low[WORD_W-1 -: BYTE_W]
               && emitted < MAX_BYTES_PER_REQUEST)
        begin
            b.out_byte    = bound_high[WORD_W-1 -: BYTE_W];
            b.last_of_run = 1'b0;
            owed_bytes.push_back(b);
            emitted++;
            bound_high = {bound_high[rbo_pkg::TOP_SHIFT-1:0], rbo_pkg::BYTE_FILL};
            bound_low  = {bound_low[rbo_pkg::TOP_SHIFT-1:0], 8'h00};
        end
    endtask

    // Narrow the interval for one request and queue the bytes it gives
    task automatic predict_bytes(rbo_pkg::sym_item_t req);
        int                emitted;
        logic [WORD_W-1:0] mult;
        emitted = 0;
        if (req.operation == rbo_pkg::OP_FLUSH)
        begin
            bound_high = bound_low;
            shift_agreeing_bytes(emitted);
        end
        else
        begin
            mult = span_quotient(bound_high - bound_low, req.total);
            // interval narrower than the total: push out low and retry
            if (mult == '0)
            begin
                bound_high = bound_low;
                shift_agreeing_bytes(emitted);
                mult = span_quotient(bound_high - bound_low, req.total);
            end
            bound_low  = bound_low + WORD_W'(req.cum_start) * mult;
            bound_high = bound_low + WORD_W'(req.freq) * mult - 1;
            shift_agreeing_bytes(emitted);
        end
        if (emitted > 0)
            owed_bytes[owed_bytes.size()-1].last_of_run = 1'b1;
    endtask

    // Compare accepted bytes, then predict from accepted requests
    always @(posedge clk or negedge rst_n)
    begin
        rbo_pkg::byte_item_t want;
        if (!rst_n)
        begin
            bound_low  = rbo_pkg::LOW_INIT;
            bound_high = rbo_pkg::HIGH_INIT;
            owed_bytes.delete();
            mismatches = 0;
        end
        else
        begin
            if (byte_mon.valid && byte_mon.ready)
            begin
                if (owed_bytes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: byte %02h last %0b arrived, expected none",
                             $time, byte_mon.data.out_byte, byte_mon.data.last_of_run);
                end
                else
                begin
                    want = owed_bytes.pop_front();
                    if (byte_mon.data.out_byte !== want.out_byte)
                    begin
                        mismatches++;
                        $display("%0t ns: out_byte expected %02h, got %02h",
                                 $time, want.out_byte, byte_mon.data.out_byte);
                    end
                    if (byte_mon.data.last_of_run !== want.last_of_run)
                    begin
                        mismatches++;
                        $display("%0t ns: last_of_run expected %0b, got %0b",
                                 $time, want.last_of_run, byte_mon.data.last_of_run);
                    end
                end
            end
            if (sym_mon.valid && sym_mon.ready)
                predict_bytes(sym_mon.data);
        end
        outstanding = owed_bytes.size();
    end

endmodule

// ===== verif/tb_range_encoder_byte_output_core.sv =====
// ----------------------------------------------------------------------------
// tb_range_encoder_byte_output_core
// Drives symbol and flush requests into the range encoder: a directed set of
// corner cases, then random well-formed and noisy requests under several
// idling patterns, a long output hold-off and a full drain pause. The byte
// checker beside the block scores the output.
// ----------------------------------------------------------------------------
module tb_range_encoder_byte_output_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    localparam int          PHASE_REQUESTS = 98;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DRAIN_CYCLES   = 200;
    localparam int unsigned CYCLE_LIMIT    = 400000;
    localparam int          CUM_W          = rbo_pkg::CUM_W;
    localparam int          FREQ_W         = rbo_pkg::FREQ_W;
    localparam int          TOTAL_W        = rbo_pkg::TOTAL_W;

    logic        clk;
    logic        rst_n;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_requests;
    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned outstanding;

    rbo_sym_if  sym_chan();
    rbo_byte_if byte_chan();

    range_encoder_byte_output_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sym_chan  (sym_chan),
        .byte_chan (byte_chan)
    );

    range_coder_byte_checker byte_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sym_mon     (sym_chan),
        .byte_mon    (byte_chan),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // Byte receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int unsigned holds_served;
        holds_served    = 0;
        byte_chan.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                byte_chan.ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(negedge clk);
            end
            byte_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic rbo_pkg::sym_item_t make_request(
        logic               op,
        logic [CUM_W-1:0]   cum,
        logic [FREQ_W-1:0]  frq,
        logic [TOTAL_W-1:0] tot
    );
        rbo_pkg::sym_item_t r;
        r.operation = op;
        r.cum_start = cum;
        r.freq      = frq;
        r.total     = tot;
        return r;
    endfunction

    // Mostly well-formed symbols, some flushes, some arbitrary field values
    function automatic rbo_pkg::sym_item_t random_request();
        rbo_pkg::sym_item_t r;
        int unsigned        pick;
        int unsigned        tot;
        int unsigned        frq;
        pick = $urandom_range(99);
        r = make_request(rbo_pkg::OP_ENCODE, CUM_W'($urandom), FREQ_W'($urandom),
                         TOTAL_W'($urandom));
        if (pick < 8)
            r.operation = rbo_pkg::OP_FLUSH;
        else if (pick >= 20)
        begin
            case ($urandom_range(2))
                0:       tot = $urandom_range(1, 16);
                1:       tot = $urandom_range(17, 4096);
                default: tot = $urandom_range(4097, 40960);
            endcase
            frq = $urandom_range(1, (tot < 160) ? tot : 160);
            r.total     = TOTAL_W'(tot);
            r.freq      = FREQ_W'(frq);
            r.cum_start = CUM_W'($urandom_range(0, tot - frq));
        end
        return r;
    endfunction

    // Hand one request over; returns on the falling edge after acceptance
    task automatic send_request(rbo_pkg::sym_item_t req);
        while ($urandom_range(99) < send_idle_pct)
        begin
            sym_chan.valid <= 1'b0;
            @(negedge clk);
        end
        sym_chan.valid <= 1'b1;
        sym_chan.data  <= req;
        do
            @(posedge clk);
        while (!sym_chan.ready);
        @(negedge clk);
    endtask

    // Leave the interval straddling a byte boundary so the next symbol
    // finds it narrower than its total
    task automatic squeeze_interval();
        send_request(make_request(rbo_pkg::OP_FLUSH, CUM_W'($urandom),
                                  FREQ_W'($urandom), TOTAL_W'($urandom)));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'h00FF, 8'd1, 16'hFFFF));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'h7F00, 8'hFF, 16'h8000));
        send_request(make_request(rbo_pkg::OP_ENCODE, CUM_W'($urandom_range(0, 255)),
                                  FREQ_W'($urandom_range(1, 160)),
                                  TOTAL_W'($urandom_range(16'h0200, 16'hFFFF))));
    endtask

    // Stop offering until every owed byte has come out
    task automatic pause_until_drained();
        sym_chan.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
    endtask

    task automatic set_idling(idle_mode_t mode);
        send_idle_pct  = (mode == IDLE_SEND) ? 51 : (mode == IDLE_BOTH) ? 33 : 0;
        recv_stall_pct = (mode == IDLE_RECV) ? 51 : (mode == IDLE_BOTH) ? 33 : 0;
    endtask

    // Stimulus and verdict
    initial
    begin
        int         sent;
        idle_mode_t mode;
        logic       drained_once;
        logic       held_once;
        rst_n          = 1'b0;
        hold_requests  = 0;
        drained_once   = 1'b0;
        held_once      = 1'b0;
        sym_chan.valid = 1'b0;
        sym_chan.data  = '0;
        set_idling(IDLE_NONE);
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: flush from reset, zero total and zero freq, field
        // extremes, wrapping products, a zero mult, alternating bit patterns
        send_request(make_request(rbo_pkg::OP_FLUSH, 16'd0, 8'd0, 16'd0));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'd0, 8'd1, 16'd1));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'd0, 8'hFF, 16'd0));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'hFFFF, 8'd0, 16'hFFFF));
        send_request(make_request(rbo_pkg::OP_FLUSH, 16'hFFFF, 8'hFF, 16'hFFFF));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'd40800, 8'd160, 16'd40960));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'd0, 8'd1, 16'd40960));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'hFFFF, 8'hFF, 16'hFFFF));
        send_request(make_request(rbo_pkg::OP_FLUSH, 16'hFFFF, 8'hFF, 16'hFFFF));
        squeeze_interval();
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'hAAAA, 8'h55, 16'h5555));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'h5555, 8'hAA, 16'hAAAA));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'd1, 8'd1, 16'd2));
        send_request(make_request(rbo_pkg::OP_ENCODE, 16'd39, 8'd1, 16'd40));
        send_request(make_request(rbo_pkg::OP_FLUSH, 16'd0, 8'd0, 16'd0));

        // Random requests under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            mode = idle_mode_t'(p);
            set_idling(mode);
            sent = 0;
            while (sent < PHASE_REQUESTS)
            begin
                if (mode == IDLE_NONE && sent >= 50 && !drained_once)
                begin
                    pause_until_drained();
                    drained_once = 1'b1;
                end
                if (mode == IDLE_RECV && sent >= 20 && !held_once)
                begin
                    hold_requests++;
                    held_once = 1'b1;
                end
                if ($urandom_range(29) == 0)
                begin
                    squeeze_interval();
                    sent += 4;
                end
                else
                begin
                    send_request(random_request());
                    sent++;
                end
            end
        end

        sym_chan.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/rbo_pkg.sv
rtl/rbo_stream_if.sv
rtl/rbo_div.sv
rtl/range_encoder_byte_output_core.sv
rtl/rbo_checker.sv
verif/range_coder_byte_checker.sv
verif/tb_range_encoder_byte_output_core.sv
